>>> rtl/gnos_pkg.sv
// Shared types, constants and the permutation table of the gradient noise block.
package gnos_pkg;

    localparam int unsigned DEF_MAX_OCTAVES     = 8;
    localparam int unsigned DEF_COORD_FRAC_BITS = 16;

    localparam int unsigned COORD_W    = 32;
    localparam int unsigned SEED_W     = 8;
    localparam int unsigned OCT_CFG_W  = 4;
    localparam int unsigned PERS_W     = 16;
    localparam int unsigned NOISE_W    = 16;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_SEED    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_OCTAVES = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PERSIST = 2'd2;

    localparam logic [SEED_W-1:0]    SEED_RST    = 8'd0;
    localparam logic [OCT_CFG_W-1:0] OCTAVES_RST = 4'd4;
    localparam logic [PERS_W-1:0]    PERSIST_RST = 16'd8192;

    // shared multiplier: signed 34 x 22 bits
    localparam int unsigned MUL_A_W = 34;
    localparam int unsigned MUL_B_W = 22;
    localparam int unsigned PROD_W  = 56;
    // signed Q16 gradient and interpolation values
    localparam int unsigned VAL_W   = 20;
    localparam int unsigned DIFF_W  = 21;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned FADE_W  = 17;
    localparam int unsigned FADEC_W = 20;

    localparam int unsigned FREQ_W     = 32;
    localparam int unsigned FREQ_SHIFT = 14;
    localparam int unsigned FREQ_DVD_W = FREQ_W + FREQ_SHIFT;

    localparam logic [31:0]        Q16_ONE   = 32'd65536;
    localparam logic [FADEC_W-1:0] FADE_K15  = 20'd983040;
    localparam logic [FADEC_W-1:0] FADE_K10  = 20'd655360;

    localparam logic [7:0] PERM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // datapath step issued by the sequencer, one per cycle except while OP_FREQ, OP_FWAIT or OP_OUT waits
    typedef enum logic [4:0] {
        OP_NOP,
        OP_MXL,   // x * freq low half
        OP_MXH,   // x * freq high half
        OP_MYL,   // assemble x cell, y * freq low half
        OP_MYH,   // y * freq high half
        OP_HASH1, // assemble y cell, first hash level, fade x start
        OP_HASH2, // corner hashes
        OP_FX3,
        OP_FX4,
        OP_FY1,
        OP_FY2,
        OP_FY3,
        OP_FY4,
        OP_GRAD,  // fade y done, corner gradients
        OP_L1,
        OP_L2,
        OP_L3,
        OP_L4,
        OP_L5,
        OP_ACC1,  // strength * sample
        OP_ACC2,  // accumulate, strength * persistence
        OP_NEXT,  // new strength, start frequency divide
        OP_FREQ,  // wait for frequency quotient
        OP_FIN,   // start normalizing divide
        OP_FWAIT, // wait for normalized quotient
        OP_OUT    // move result to output register
    } gnos_op_t;

    typedef struct packed {
        logic     load;
        gnos_op_t op;
    } gnos_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } gnos_stat_t;

endpackage

>>> rtl/gradient_noise_octave_sum.sv
// Top level of the fractal 2D gradient noise block: register port, sequencer, datapath.
//
// Takes one request of two signed Q16.16 coordinates (x in s_tdata[31:0], y in
// s_tdata[63:32]) and returns one signed Q2.14 noise value, the strength-weighted
// sum of octave_count octaves of gradient noise divided by four times the total
// strength and saturated to 16 bits. The block works on one request at a time:
// every octave runs through a single shared 34x22 multiplier and the permutation
// table, then through the bit-serial divider that forms the next frequency (the
// last octave skips that divide), and the final normalization takes one divider
// pass that forms one quotient bit for each accumulator bit (54 at the default
// octave limit). A finished value sits in the output register until taken; a new
// request is accepted once that value has been handed over or parked there.
// Registers (APB, byte address 4*i): seed at 0, octave_count at 4, persistence at 8;
// write them only while the block is idle.
module gradient_noise_octave_sum #(
    parameter int unsigned MAX_OCTAVES     = gnos_pkg::DEF_MAX_OCTAVES,
    parameter int unsigned COORD_FRAC_BITS = gnos_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gnos_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [gnos_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [gnos_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [2*gnos_pkg::COORD_W-1:0]     s_tdata,   // coord_x, coord_y
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gnos_pkg::NOISE_W-1:0]       m_tdata    // noise_value
);
    import gnos_pkg::*;

    logic [SEED_W-1:0]    seed_reg;
    logic [OCT_CFG_W-1:0] octaves_reg;
    logic [PERS_W-1:0]    persist_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    gnos_cmd_t            cmd;
    gnos_stat_t           stat;
    logic signed [NOISE_W-1:0] noise_value;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // register writes; addresses past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg    <= SEED_RST;
            octaves_reg <= OCTAVES_RST;
            persist_reg <= PERSIST_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_SEED:    seed_reg    <= pwdata[SEED_W-1:0];
                REG_OCTAVES: octaves_reg <= pwdata[OCT_CFG_W-1:0];
                REG_PERSIST: persist_reg <= pwdata[PERS_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            REG_SEED:    prdata = APB_DATA_W'(seed_reg);
            REG_OCTAVES: prdata = APB_DATA_W'(octaves_reg);
            REG_PERSIST: prdata = APB_DATA_W'(persist_reg);
            default:     prdata = '0;
        endcase
    end

    gnos_ctrl #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .octave_count (octaves_reg),
        .stat         (stat),
        .cmd          (cmd)
    );

    gnos_dp #(
        .MAX_OCTAVES     (MAX_OCTAVES),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .coord_x     (s_tdata[COORD_W-1:0]),
        .coord_y     (s_tdata[2*COORD_W-1:COORD_W]),
        .seed        (seed_reg),
        .persistence (persist_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .noise_value (noise_value)
    );

    assign m_tdata = noise_value;

endmodule

>>> rtl/gnos_div.sv
// Restoring serial divider, one quotient bit per cycle.
module gnos_div #(
    parameter int unsigned N_W   = 54,
    parameter int unsigned D_W   = 38,
    parameter int unsigned CNT_W = $clog2(N_W + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [N_W-1:0]   dividend,  // left aligned
    input  logic [D_W-1:0]   divisor,
    input  logic [CNT_W-1:0] iters,
    output logic             busy,
    output logic             done,
    output logic [N_W-1:0]   quotient
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [N_W-1:0]   dvd_reg;
    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   div_reg;
    logic [D_W:0]     rem_try;
    logic             take;
    logic [D_W:0]     rem_sub;

    assign rem_try = {rem_reg, dvd_reg[N_W-1]};
    assign take    = rem_try >= {1'b0, div_reg};
    assign rem_sub = rem_try - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[N_W-2:0], 1'b0};
            rem_reg <= take ? rem_sub[D_W-1:0] : rem_try[D_W-1:0];
            quo_reg <= {quo_reg[N_W-2:0], take};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_last_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !start && cnt_reg == CNT_W'(1)) |=> done_reg)
        else $error("divider missed its done pulse");

endmodule

>>> rtl/gnos_dp.sv
// Datapath: shared multiplier, hash lookups, fade, blending, accumulation and divides.
module gnos_dp #(
    parameter int unsigned MAX_OCTAVES     = gnos_pkg::DEF_MAX_OCTAVES,
    parameter int unsigned COORD_FRAC_BITS = gnos_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  gnos_pkg::gnos_cmd_t               cmd,
    output gnos_pkg::gnos_stat_t              stat,
    input  logic signed [gnos_pkg::COORD_W-1:0] coord_x,
    input  logic signed [gnos_pkg::COORD_W-1:0] coord_y,
    input  logic [gnos_pkg::SEED_W-1:0]       seed,
    input  logic [gnos_pkg::PERS_W-1:0]       persistence,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic signed [gnos_pkg::NOISE_W-1:0] noise_value
);
    import gnos_pkg::*;

    localparam int unsigned LOG_OCT = $clog2(MAX_OCTAVES + 1);
    localparam int unsigned ACC_W   = 50 + LOG_OCT;
    localparam int unsigned TOT_W   = 32 + LOG_OCT;
    localparam int unsigned DIV_N   = ACC_W;
    localparam int unsigned DIV_D   = TOT_W + 2;
    localparam int unsigned CNT_W   = $clog2(DIV_N + 1);
    localparam int unsigned PW      = COORD_FRAC_BITS + 24;

    function automatic logic [FADE_W-1:0] fade_clamp(input logic [FADEC_W-1:0] f);
        if (f > FADEC_W'(Q16_ONE)) begin
            return FADE_W'(Q16_ONE);
        end
        return f[FADE_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] grad(input logic [1:0] h,
                                                      input logic signed [VAL_W-1:0] dx,
                                                      input logic signed [VAL_W-1:0] dy);
        logic signed [VAL_W-1:0] g;
        unique case (h)
            2'd0:    g = dx + dy;
            2'd1:    g = dy - dx;
            2'd2:    g = -dx - dy;
            default: g = dx - dy;
        endcase
        return g;
    endfunction

    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic [FREQ_W-1:0]         freq_reg, str_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [TOT_W-1:0]          total_reg;
    logic [7:0]                xoff_reg, yoff_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [PW-1:0]             lo_reg;
    logic [7:0]                cx_reg, cy_reg, h0_reg, h1_reg;
    logic [FRAC_W-1:0]         fx_reg, fy_reg;
    logic [1:0]                hbl_reg, htl_reg, hbr_reg, htr_reg;
    logic [FADEC_W-1:0]        c_reg;
    logic [FADE_W-1:0]         u_reg, v_reg;
    logic signed [VAL_W-1:0]   gbl_reg, gtl_reg, gbr_reg, gtr_reg;
    logic signed [VAL_W-1:0]   x1_reg, x2_reg, sample_reg;
    logic signed [NOISE_W-1:0] res_reg;
    logic signed [NOISE_W-1:0] out_reg;
    logic                      out_valid_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [PW-1:0]             p_sum;
    logic [FADEC_W-1:0]        fx_lin, fy_lin;
    logic signed [VAL_W-1:0]   dx0, dx1, dy0, dy1, lerp_part;
    logic signed [DIFF_W-1:0]  diff_y0, diff_y1, diff_x;
    logic [FADEC_W-1:0]        fade_hi;
    logic [7:0]                h0_idx;

    logic                      div_start, div_busy, div_done;
    logic [DIV_N-1:0]          div_dvd, quo;
    logic [DIV_D-1:0]          div_dsr;
    logic [CNT_W-1:0]          div_iters;
    logic [ACC_W-1:0]          acc_mag;
    logic                      out_free;

    assign p_sum     = lo_reg + {prod_reg[PW-17:0], 16'b0};
    assign fx_lin    = FADE_K15 - (FADEC_W'({fx_reg, 2'b0}) + FADEC_W'({fx_reg, 1'b0}));
    assign fy_lin    = FADE_K15 - (FADEC_W'({fy_reg, 2'b0}) + FADEC_W'({fy_reg, 1'b0}));
    assign fade_hi   = prod_reg[35:16];
    assign lerp_part = prod_reg[16+VAL_W-1:16];
    assign dx0       = VAL_W'(signed'({1'b0, fx_reg}));
    assign dy0       = VAL_W'(signed'({1'b0, fy_reg}));
    assign dx1       = dx0 - VAL_W'(signed'({1'b0, Q16_ONE[16:0]}));
    assign dy1       = dy0 - VAL_W'(signed'({1'b0, Q16_ONE[16:0]}));
    assign diff_y0   = DIFF_W'(gtl_reg) - DIFF_W'(gbl_reg);
    assign diff_y1   = DIFF_W'(gtr_reg) - DIFF_W'(gbr_reg);
    assign diff_x    = DIFF_W'(x2_reg) - DIFF_W'(x1_reg);
    assign h0_idx    = cx_reg + 8'd1;
    assign acc_mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign out_free  = !out_valid_reg || m_tready;

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MXL:  begin mul_a = MUL_A_W'(x_reg); mul_b = MUL_B_W'({1'b0, freq_reg[15:0]}); end
            OP_MXH:  begin mul_a = MUL_A_W'(x_reg); mul_b = MUL_B_W'({1'b0, freq_reg[31:16]}); end
            OP_MYL:  begin mul_a = MUL_A_W'(y_reg); mul_b = MUL_B_W'({1'b0, freq_reg[15:0]}); end
            OP_MYH:  begin mul_a = MUL_A_W'(y_reg); mul_b = MUL_B_W'({1'b0, freq_reg[31:16]}); end
            OP_HASH1: begin mul_a = MUL_A_W'({1'b0, fx_reg}); mul_b = MUL_B_W'({1'b0, fx_lin}); end
            OP_HASH2: begin mul_a = MUL_A_W'({1'b0, fx_reg}); mul_b = MUL_B_W'({1'b0, fx_reg}); end
            OP_FX3:  begin
                mul_a = MUL_A_W'({1'b0, prod_reg[31:16]});
                mul_b = MUL_B_W'({1'b0, fx_reg});
            end
            OP_FX4, OP_FY4: begin
                mul_a = MUL_A_W'({1'b0, prod_reg[31:16]});
                mul_b = MUL_B_W'({1'b0, c_reg});
            end
            OP_FY1:  begin mul_a = MUL_A_W'({1'b0, fy_reg}); mul_b = MUL_B_W'({1'b0, fy_lin}); end
            OP_FY2:  begin mul_a = MUL_A_W'({1'b0, fy_reg}); mul_b = MUL_B_W'({1'b0, fy_reg}); end
            OP_FY3:  begin
                mul_a = MUL_A_W'({1'b0, prod_reg[31:16]});
                mul_b = MUL_B_W'({1'b0, fy_reg});
            end
            OP_L1:   begin mul_a = MUL_A_W'(diff_y0); mul_b = MUL_B_W'({1'b0, v_reg}); end
            OP_L2:   begin mul_a = MUL_A_W'(diff_y1); mul_b = MUL_B_W'({1'b0, v_reg}); end
            OP_L4:   begin mul_a = MUL_A_W'(diff_x);  mul_b = MUL_B_W'({1'b0, u_reg}); end
            OP_ACC1: begin mul_a = MUL_A_W'({1'b0, str_reg}); mul_b = MUL_B_W'(sample_reg); end
            OP_ACC2: begin
                mul_a = MUL_A_W'({1'b0, str_reg});
                mul_b = MUL_B_W'({1'b0, persistence});
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // divider request: next frequency or final normalization
    always_comb begin
        div_start = (cmd.op == OP_NEXT) || (cmd.op == OP_FIN);
        if (cmd.op == OP_FIN) begin
            div_dvd   = DIV_N'(acc_mag);
            div_dsr   = {total_reg, 2'b00};
            div_iters = CNT_W'(DIV_N);
        end else begin
            div_dvd   = DIV_N'({freq_reg, {FREQ_SHIFT{1'b0}}}) << (DIV_N - FREQ_DVD_W);
            div_dsr   = DIV_D'(persistence);
            div_iters = CNT_W'(FREQ_DVD_W);
        end
    end

    gnos_div #(
        .N_W   (DIV_N),
        .D_W   (DIV_D),
        .CNT_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .iters    (div_iters),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load) begin
            x_reg     <= coord_x;
            y_reg     <= coord_y;
            freq_reg  <= Q16_ONE;
            str_reg   <= Q16_ONE;
            acc_reg   <= '0;
            total_reg <= '0;
            xoff_reg  <= PERM[seed];
            yoff_reg  <= PERM[8'(seed + 8'd1)];
        end
        unique case (cmd.op)
            OP_MXH, OP_MYH: lo_reg <= prod_reg[PW-1:0];
            OP_MYL: begin
                cx_reg <= p_sum[PW-1:PW-8] + xoff_reg;
                fx_reg <= p_sum[COORD_FRAC_BITS+15:COORD_FRAC_BITS];
            end
            OP_HASH1: begin
                cy_reg <= p_sum[PW-1:PW-8] + yoff_reg;
                fy_reg <= p_sum[COORD_FRAC_BITS+15:COORD_FRAC_BITS];
                h0_reg <= PERM[cx_reg];
                h1_reg <= PERM[h0_idx];
            end
            OP_HASH2: begin
                hbl_reg <= PERM[8'(h0_reg + cy_reg)][1:0];
                htl_reg <= PERM[8'(h0_reg + cy_reg + 8'd1)][1:0];
                hbr_reg <= PERM[8'(h1_reg + cy_reg)][1:0];
                htr_reg <= PERM[8'(h1_reg + cy_reg + 8'd1)][1:0];
                c_reg   <= FADE_K10 - fade_hi;
            end
            OP_FY1: u_reg <= fade_clamp(fade_hi);
            OP_FY2: c_reg <= FADE_K10 - fade_hi;
            OP_GRAD: begin
                v_reg   <= fade_clamp(fade_hi);
                gbl_reg <= grad(hbl_reg, dx0, dy0);
                gtl_reg <= grad(htl_reg, dx0, dy1);
                gbr_reg <= grad(hbr_reg, dx1, dy0);
                gtr_reg <= grad(htr_reg, dx1, dy1);
            end
            OP_L2:   x1_reg     <= gbl_reg + lerp_part;
            OP_L3:   x2_reg     <= gbr_reg + lerp_part;
            OP_L5:   sample_reg <= x1_reg + lerp_part;
            OP_ACC1: total_reg  <= total_reg + TOT_W'(str_reg);
            OP_ACC2: acc_reg    <= acc_reg + ACC_W'(prod_reg);
            OP_NEXT: begin
                if (prod_reg[47:46] != 2'b00) begin
                    str_reg <= '1;
                end else begin
                    str_reg <= prod_reg[45:14];
                end
            end
            OP_FREQ: begin
                if (div_done) begin
                    freq_reg <= (quo[DIV_N-1:FREQ_W] != '0) ? '1 : quo[FREQ_W-1:0];
                end
            end
            OP_FWAIT: begin
                if (div_done) begin
                    if (acc_reg[ACC_W-1]) begin
                        res_reg <= (quo > DIV_N'(32768)) ? NOISE_W'(-32768)
                                                         : NOISE_W'(-quo[NOISE_W:0]);
                    end else begin
                        res_reg <= (quo > DIV_N'(32767)) ? NOISE_W'(32767)
                                                         : quo[NOISE_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // output register: hold result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((cmd.op == OP_OUT) && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((cmd.op == OP_OUT) && out_free) begin
            out_reg <= res_reg;
        end
    end

    assign stat.div_done = div_done && !div_busy;
    assign stat.out_free = out_free;
    assign m_tvalid      = out_valid_reg;
    assign noise_value   = out_reg;

endmodule

>>> rtl/gnos_ctrl.sv
// Sequencer: octave loop and per-step commands for the datapath.
module gnos_ctrl #(
    parameter int unsigned MAX_OCTAVES = gnos_pkg::DEF_MAX_OCTAVES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gnos_pkg::OCT_CFG_W-1:0]   octave_count,
    input  gnos_pkg::gnos_stat_t             stat,
    output gnos_pkg::gnos_cmd_t              cmd
);
    import gnos_pkg::*;

    localparam int unsigned OCT_W = $clog2(MAX_OCTAVES + 1);

    typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_WAIT_F, ST_WAIT_Q, ST_OUT} state_t;

    state_t           state_reg;
    gnos_op_t         op_reg;
    logic [OCT_W-1:0] oct_reg;
    logic [OCT_W-1:0] cnt_reg;
    logic [OCT_W-1:0] cnt_next;
    logic             load;

    // zero runs one octave, above the maximum clamps
    always_comb begin
        if (octave_count == '0) begin
            cnt_next = OCT_W'(1);
        end else if (32'(octave_count) > MAX_OCTAVES) begin
            cnt_next = OCT_W'(MAX_OCTAVES);
        end else begin
            cnt_next = OCT_W'(octave_count);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign load     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_NOP;
            oct_reg   <= OCT_W'(1);
            cnt_reg   <= OCT_W'(1);
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_RUN;
                        op_reg    <= OP_MXL;
                        oct_reg   <= OCT_W'(1);
                        cnt_reg   <= cnt_next;
                    end
                end
                ST_RUN: begin
                    unique case (op_reg)
                        OP_MXL:   op_reg <= OP_MXH;
                        OP_MXH:   op_reg <= OP_MYL;
                        OP_MYL:   op_reg <= OP_MYH;
                        OP_MYH:   op_reg <= OP_HASH1;
                        OP_HASH1: op_reg <= OP_HASH2;
                        OP_HASH2: op_reg <= OP_FX3;
                        OP_FX3:   op_reg <= OP_FX4;
                        OP_FX4:   op_reg <= OP_FY1;
                        OP_FY1:   op_reg <= OP_FY2;
                        OP_FY2:   op_reg <= OP_FY3;
                        OP_FY3:   op_reg <= OP_FY4;
                        OP_FY4:   op_reg <= OP_GRAD;
                        OP_GRAD:  op_reg <= OP_L1;
                        OP_L1:    op_reg <= OP_L2;
                        OP_L2:    op_reg <= OP_L3;
                        OP_L3:    op_reg <= OP_L4;
                        OP_L4:    op_reg <= OP_L5;
                        OP_L5:    op_reg <= OP_ACC1;
                        OP_ACC1:  op_reg <= OP_ACC2;
                        OP_ACC2:  op_reg <= (oct_reg == cnt_reg) ? OP_FIN : OP_NEXT;
                        OP_NEXT: begin
                            op_reg    <= OP_FREQ;
                            state_reg <= ST_WAIT_F;
                        end
                        OP_FIN: begin
                            op_reg    <= OP_FWAIT;
                            state_reg <= ST_WAIT_Q;
                        end
                        default: begin
                            op_reg    <= OP_NOP;
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_WAIT_F: begin
                    if (stat.div_done) begin
                        op_reg    <= OP_MXL;
                        state_reg <= ST_RUN;
                        oct_reg   <= oct_reg + OCT_W'(1);
                    end
                end
                ST_WAIT_Q: begin
                    if (stat.div_done) begin
                        op_reg    <= OP_OUT;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (stat.out_free) begin
                        op_reg    <= OP_NOP;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    op_reg    <= OP_NOP;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cmd.load = load;
    assign cmd.op   = op_reg;

    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (op_reg == OP_MXL) && (oct_reg == OCT_W'(1)))
        else $error("accepted request did not start the first octave");

    a_oct_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (oct_reg <= cnt_reg) && (oct_reg != '0))
        else $error("octave counter out of range");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (op_reg == OP_NOP))
        else $error("datapath command issued while idle");

endmodule
